[src/mtkd_pkg.sv]
package mtkd_pkg;

   // Input item kinds, carried on req_tuser
   localparam logic KIND_KEY = 1'b0;
   localparam logic KIND_END = 1'b1;

   // Keypad symbol codes that need special handling
   localparam logic [3:0] KEY_SPACE     = 4'd1;
   localparam logic [3:0] KEY_FIRST_ABC = 4'd2;
   localparam logic [3:0] KEY_LAST_ABC  = 4'd9;
   localparam logic [3:0] KEY_PQRS      = 4'd7;
   localparam logic [3:0] KEY_WXYZ      = 4'd9;
   localparam logic [3:0] KEY_SEPARATOR = 4'd14;

   // Press counts wrap at the least common multiple of the group sizes
   localparam logic [3:0] COUNT_LAST = 4'd11;

   localparam logic [6:0] CHAR_SPACE  = 7'h20;
   localparam logic [6:0] CHAR_PERIOD = 7'h2E;

   // First letter of each letter group, keys 2 to 9
   localparam logic [6:0] GROUP_BASE [8] = '{
      7'h61, 7'h64, 7'h67, 7'h6A, 7'h6D, 7'h70, 7'h74, 7'h77
   };

   // (count - 1) mod 3, for counts 0 to 15
   localparam logic [1:0] POS3 [16] = '{
      2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
      2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2
   };

   typedef struct packed {
      logic       fire;
      logic       kind;
      logic [3:0] key;
   } step_type;

   typedef struct packed {
      logic       emit;
      logic [6:0] text_char;
   } result_type;

   // Character for a closed run of the given key and press count
   function automatic logic [6:0] decode_run(logic [3:0] key, logic [3:0] count);
      logic [3:0] group;
      logic [3:0] count_m1;
      logic [1:0] pos;
      logic [6:0] dec;
      group    = key - KEY_FIRST_ABC;
      count_m1 = count + 4'd3;
      if (key == KEY_PQRS || key == KEY_WXYZ) begin
         pos = count_m1[1:0];
      end else begin
         pos = POS3[count];
      end
      if (key == KEY_SPACE) begin
         dec = CHAR_SPACE;
      end else if (key inside {[KEY_FIRST_ABC:KEY_LAST_ABC]}) begin
         dec = GROUP_BASE[group[2:0]] + {5'd0, pos};
      end else begin
         dec = CHAR_PERIOD;
      end
      return dec;
   endfunction

endpackage

[src/mtkd_run_ctl.sv]
module mtkd_run_ctl (
   input  logic                  clock,
   input  logic                  reset,
   input  mtkd_pkg::step_type    step,
   output mtkd_pkg::result_type  result
);

   logic [3:0] run_key_ff, run_key_in;
   logic [3:0] run_count_ff, run_count_in;
   logic       run_active_ff, run_active_in;
   logic [6:0] run_char;

   assign run_char = mtkd_pkg::decode_run(run_key_ff, run_count_ff);

   always_comb begin
      run_key_in    = run_key_ff;
      run_count_in  = run_count_ff;
      run_active_in = run_active_ff;
      result.emit      = 1'b0;
      result.text_char = run_char;
      if (step.kind == mtkd_pkg::KIND_END) begin
         result.emit   = run_active_ff;
         run_active_in = 1'b0;
         run_key_in    = 4'd0;
         run_count_in  = 4'd0;
      end else if (step.key == mtkd_pkg::KEY_SEPARATOR) begin
         result.emit = 1'b1;
         if (!run_active_ff) begin
            result.text_char = mtkd_pkg::CHAR_PERIOD;
         end
         run_active_in = 1'b0;
         run_key_in    = 4'd0;
         run_count_in  = 4'd0;
      end else if (run_active_ff && step.key == run_key_ff) begin
         run_count_in = (run_count_ff == mtkd_pkg::COUNT_LAST) ? 4'd0 : run_count_ff + 4'd1;
      end else begin
         // A new key closes any open run and opens its own
         result.emit   = run_active_ff;
         run_active_in = 1'b1;
         run_key_in    = step.key;
         run_count_in  = 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_key_ff    <= 4'd0;
         run_count_ff  <= 4'd0;
         run_active_ff <= 1'b0;
      end else if (step.fire) begin
         run_key_ff    <= run_key_in;
         run_count_ff  <= run_count_in;
         run_active_ff <= run_active_in;
      end
   end

endmodule

[src/multitap_keypad_text_decoder.sv]
// Multi-tap keypad text decoder on the E.161 letter layout.
//
// Input channel (req_): one item per keypad event. req_tuser is the kind
// (0 = key press, 1 = end of message) and req_tdata[3:0] is the key code.
// Presses of the same key in a row form a run; a different key, the
// separator key or an end-of-message item closes the run and sends its
// character. Result channel (rsp_): one item per decoded character, ASCII
// in rsp_tdata[6:0], bit 7 always zero.
//
// rsp_tvalid rises once the closing item has passed from the input register,
// where its decode is formed, into the result register. Throughput is one
// item per cycle while no emitting item waits on a stalled result; the only
// loop is the run state update.
//
// Reset clears the run state and the valid flags of both registers, so
// no run is open and no result is pending. When the receiver stalls, the
// result register holds its item and the input register may still take
// one more item; an item that sends no character passes on regardless,
// so only items that must emit wait behind a stalled result.
module multitap_keypad_text_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [3:0] key, [7:4] zero
   input  logic       req_tuser,   // [0] kind
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [6:0] text_char, [7] zero
);

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic       in_kind_ff;
   logic [3:0] in_key_ff;

   // Result register
   logic       out_valid_ff, out_valid_in;
   logic [6:0] out_char_ff;

   mtkd_pkg::step_type   step;
   mtkd_pkg::result_type result;
   logic                 in_fire;
   logic                 req_fire;

   // The held item moves on unless it emits into a full, stalled result slot.
   assign in_fire    = in_valid_ff && (!result.emit || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || in_fire;
   assign req_fire   = req_tvalid && req_tready;

   assign step.fire = in_fire;
   assign step.kind = in_kind_ff;
   assign step.key  = in_key_ff;

   mtkd_run_ctl u_run_ctl (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .result (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (in_fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (in_fire && result.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff <= req_tuser;
         in_key_ff  <= req_tdata[3:0];
      end
      if (in_fire && result.emit) begin
         out_char_ff <= result.text_char;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_char_ff};

endmodule

[src/mtkd_checker.sv]
module mtkd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       req_tuser,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   logic req_fire;
   assign req_fire = req_tvalid && req_tready && (req_tuser || !req_tuser)
                     && (req_tdata == req_tdata);

   // Nothing is pending in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // A fresh result is traced back to an accepted item, across the input and result registers.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_fire, 2))
      else $error("result without a causing item");

   // Only lower-case letters, space or period are produced.
   a_rsp_char: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata >= 8'h61 && rsp_tdata <= 8'h7A)
                     || rsp_tdata == 8'h20 || rsp_tdata == 8'h2E)
      else $error("result outside the character set");

endmodule

bind multitap_keypad_text_decoder mtkd_checker u_mtkd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
